// File: rtl/u2u8_pkg.sv
// Shared types, constants and byte-forming functions for the UTF-16 to UTF-8 transcoder.
// Used by every module of the transcoder; depends on nothing.
package u2u8_pkg;

  localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
  localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
  localparam logic [15:0] SURR_END       = 16'hE000;
  localparam logic [20:0] SUPP_BASE      = 21'h10000;

  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;
  localparam logic [7:0] CONT_TAG   = 8'h80;

  // Encoded byte counts minus one.
  localparam logic [1:0] LEN_ONE   = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        has_held;
    logic [9:0]  held;
    logic        has_main;
    logic [20:0] main_cp;
    logic [1:0]  main_len;
    logic        last;
  } u2u8_cmd_t;

  function automatic logic [1:0] cp_len(input logic [20:0] cp);
    logic [1:0] len;
    if (cp < 21'h80) begin
      len = LEN_ONE;
    end else if (cp < 21'h800) begin
      len = LEN_TWO;
    end else if (cp < SUPP_BASE) begin
      len = LEN_THREE;
    end else begin
      len = LEN_FOUR;
    end
    return len;
  endfunction

  function automatic logic [7:0] cp_byte(input logic [20:0] cp, input logic [1:0] len,
                                         input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      LEN_ONE: begin
        b = {1'b0, cp[6:0]};
      end
      LEN_TWO: begin
        if (idx == 2'd0) b = LEAD_TWO | {3'b000, cp[10:6]};
        else             b = CONT_TAG | {2'b00, cp[5:0]};
      end
      LEN_THREE: begin
        case (idx)
          2'd0:    b = LEAD_THREE | {4'b0000, cp[15:12]};
          2'd1:    b = CONT_TAG | {2'b00, cp[11:6]};
          default: b = CONT_TAG | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = LEAD_FOUR | {5'b00000, cp[20:18]};
          2'd1:    b = CONT_TAG | {2'b00, cp[17:12]};
          2'd2:    b = CONT_TAG | {2'b00, cp[11:6]};
          default: b = CONT_TAG | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// File: rtl/u2u8_if.sv
// Valid/ready channel interfaces for UTF-16 code units in and UTF-8 bytes out.
// Depends on nothing.
interface u2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_last;

  modport source (output valid, output code_unit, output unit_last, input ready);
  modport sink (input valid, input code_unit, input unit_last, output ready);
endinterface

interface u2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_end,
                output ready);
endinterface

// File: rtl/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder: front end, command queue and byte serialiser.
// Depends on u2u8_pkg, u2u8_if, u2u8_front, u2u8_queue and u2u8_back.

// The serialiser drives one byte beat per cycle through its output register while the
// output is not stalled and commands are queued. A code unit produces one to four
// UTF-8 bytes: a high surrogate that pairs produces none on its own and the pair
// produces four, and an unpaired high surrogate adds three more bytes. A two-entry
// command queue lets code units be taken while earlier bytes are still being sent.
module utf16_to_utf8_transcoder (
  input  logic       clk,
  input  logic       rst,
  u2u8_in_if.sink    unit_ch,
  u2u8_out_if.source byte_ch
);
  import u2u8_pkg::*;

  logic      push_valid;
  logic      push_ready;
  u2u8_cmd_t push_cmd;
  logic      pop_valid;
  logic      pop_ready;
  u2u8_cmd_t pop_cmd;

  u2u8_front front (
    .clk        (clk),
    .rst        (rst),
    .unit_ch    (unit_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  u2u8_queue queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  u2u8_back back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .byte_ch   (byte_ch)
  );

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("command pushed into a full queue");

  a_no_empty_cmd: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |-> (pop_cmd.has_held || pop_cmd.has_main))
    else $error("queued command carries no code point");

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    (byte_ch.valid && byte_ch.string_end) |-> byte_ch.run_last)
    else $error("string end flagged on a byte that does not close its run");

  a_last_held_four: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_cmd.has_main && push_cmd.main_len == LEN_FOUR)
      |-> !push_cmd.has_held)
    else $error("surrogate pair queued together with an unpaired high surrogate");
`endif

endmodule

// File: rtl/u2u8_front.sv
// Front end: accepts code units, pairs surrogates and queues encoding commands.
// Depends on u2u8_pkg and u2u8_in_if.
module u2u8_front (
  input  logic                clk,
  input  logic                rst,
  u2u8_in_if.sink             unit_ch,
  input  logic                push_ready,
  output logic                push_valid,
  output u2u8_pkg::u2u8_cmd_t push_cmd
);
  import u2u8_pkg::*;

  logic       held_valid;
  logic [9:0] held_high;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       pair;
  logic       hold_new;
  logic [20:0] main_cp;

  assign unit_ch.ready = push_ready;
  assign accept  = unit_ch.valid && push_ready;
  assign is_high = unit_ch.code_unit[15:10] == SURR_HIGH_BASE[15:10];
  assign is_low  = unit_ch.code_unit[15:10] == SURR_LOW_BASE[15:10];
  assign pair    = held_valid && is_low;
  assign hold_new = is_high && !unit_ch.unit_last;
  assign main_cp = pair ? (SUPP_BASE + {1'b0, held_high, unit_ch.code_unit[9:0]})
                        : {5'b00000, unit_ch.code_unit};

  always_comb begin
    push_cmd.has_held = held_valid && !is_low;
    push_cmd.held     = held_high;
    push_cmd.has_main = !hold_new;
    push_cmd.main_cp  = main_cp;
    push_cmd.main_len = cp_len(main_cp);
    push_cmd.last     = unit_ch.unit_last;
  end

  assign push_valid = accept && (push_cmd.has_held || push_cmd.has_main);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_high  <= 10'd0;
    end else if (accept) begin
      held_valid <= hold_new;
      held_high  <= hold_new ? unit_ch.code_unit[9:0] : 10'd0;
    end
  end

endmodule

// File: rtl/u2u8_queue.sv
// Short command queue between the front end and the byte serialiser.
// Depends on u2u8_pkg.
module u2u8_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  u2u8_pkg::u2u8_cmd_t push_cmd,
  output logic                push_ready,
  output logic                pop_valid,
  output u2u8_pkg::u2u8_cmd_t pop_cmd,
  input  logic                pop_ready
);
  import u2u8_pkg::*;

  u2u8_cmd_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/u2u8_back.sv
// Back end: turns queued commands into UTF-8 bytes, one beat per cycle unless stalled, into an output register.
// Depends on u2u8_pkg and u2u8_out_if.
module u2u8_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  input  u2u8_pkg::u2u8_cmd_t pop_cmd,
  output logic                pop_ready,
  u2u8_out_if.source          byte_ch
);
  import u2u8_pkg::*;

  u2u8_cmd_t   cur;
  logic        cur_valid;
  logic        seg_main;
  logic [1:0]  idx;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        string_end;
  logic [20:0] seg_cp;
  logic [1:0]  seg_len;
  logic        seg_end;
  logic        cmd_end;
  logic        out_free;
  logic        emit;
  logic        load;

  assign seg_cp  = seg_main ? cur.main_cp : {5'b00000, SURR_HIGH_BASE[15:10], cur.held};
  assign seg_len = seg_main ? cur.main_len : LEN_THREE;
  assign seg_end = idx == seg_len;
  assign cmd_end = seg_end && (seg_main || !cur.has_main);
  assign out_free = !out_valid || byte_ch.ready;
  assign emit = cur_valid && out_free;
  assign pop_ready = !cur_valid || (emit && cmd_end);
  assign load = pop_valid && pop_ready;

  assign byte_ch.valid      = out_valid;
  assign byte_ch.out_byte   = out_byte;
  assign byte_ch.run_last   = run_last;
  assign byte_ch.string_end = string_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (byte_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        cur_valid <= 1'b1;
      end else if (emit && cmd_end) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= cp_byte(seg_cp, seg_len, idx);
      run_last   <= cmd_end;
      string_end <= cmd_end && cur.last;
    end
    if (load) begin
      cur      <= pop_cmd;
      seg_main <= !pop_cmd.has_held;
      idx      <= 2'd0;
    end else if (emit) begin
      if (seg_end) begin
        seg_main <= 1'b1;
        idx      <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-16 to UTF-8 transcoder, predicting every output beat.
// Depends on u2u8_pkg, the u2u8_in_if and u2u8_out_if interfaces and the transcoder top level.
module tb;
  import u2u8_pkg::*;

  localparam int          LONG_HOLD      = 60;
  localparam int          QUIET_LIMIT    = 1000;
  localparam int          TAIL_CYCLES    = 20;
  localparam logic [20:0] ONE_BYTE_LIMIT = 21'h80;
  localparam logic [20:0] TWO_BYTE_LIMIT = 21'h800;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } utf8_beat_t;

  logic clk;
  logic rst;

  u2u8_in_if  unit_ch ();
  u2u8_out_if byte_ch ();

  utf16_to_utf8_transcoder dut (
    .clk     (clk),
    .rst     (rst),
    .unit_ch (unit_ch),
    .byte_ch (byte_ch)
  );

  utf8_beat_t expected_bytes[$];
  utf8_beat_t unit_bytes[$];
  utf8_beat_t head_byte;
  logic [9:0] hi_bits    = '0;
  logic       hi_pending = 1'b0;

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_req   = 1'b0;

  int error_count   = 0;
  int units_sent    = 0;
  int strings_sent  = 0;
  int bytes_checked = 0;
  int quiet_cycles  = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void append_beat(input utf8_beat_t bt);
    unit_bytes.insert(unit_bytes.size(), bt);
  endfunction

  function automatic void emit_point(input logic [20:0] cp);
    utf8_beat_t bt;
    bt.run_last   = 1'b0;
    bt.string_end = 1'b0;
    if (cp < ONE_BYTE_LIMIT) begin
      bt.data = cp[7:0];
      append_beat(bt);
    end else if (cp < TWO_BYTE_LIMIT) begin
      bt.data = LEAD_TWO | {3'b000, cp[10:6]};
      append_beat(bt);
      bt.data = CONT_TAG | {2'b00, cp[5:0]};
      append_beat(bt);
    end else if (cp < SUPP_BASE) begin
      bt.data = LEAD_THREE | {4'b0000, cp[15:12]};
      append_beat(bt);
      bt.data = CONT_TAG | {2'b00, cp[11:6]};
      append_beat(bt);
      bt.data = CONT_TAG | {2'b00, cp[5:0]};
      append_beat(bt);
    end else begin
      bt.data = LEAD_FOUR | {5'b00000, cp[20:18]};
      append_beat(bt);
      bt.data = CONT_TAG | {2'b00, cp[17:12]};
      append_beat(bt);
      bt.data = CONT_TAG | {2'b00, cp[11:6]};
      append_beat(bt);
      bt.data = CONT_TAG | {2'b00, cp[5:0]};
      append_beat(bt);
    end
  endfunction

  function automatic void encode_unit(input logic [15:0] cu, input logic lst);
    logic is_high;
    logic is_low;
    int   n;
    is_high = (cu >= SURR_HIGH_BASE) && (cu < SURR_LOW_BASE);
    is_low  = (cu >= SURR_LOW_BASE) && (cu < SURR_END);
    unit_bytes.delete();
    if (hi_pending && is_low) begin
      hi_pending = 1'b0;
      emit_point(SUPP_BASE + {1'b0, hi_bits, 10'b0} + {11'b0, cu[9:0]});
    end else begin
      if (hi_pending) begin
        hi_pending = 1'b0;
        emit_point({5'b0, SURR_HIGH_BASE | {6'b0, hi_bits}});
      end
      if (is_high && !lst) begin
        hi_bits    = cu[9:0];
        hi_pending = 1'b1;
      end else begin
        emit_point({5'b0, cu});
      end
    end
    n = unit_bytes.size();
    if (n > 0) begin
      unit_bytes[n - 1].run_last   = 1'b1;
      unit_bytes[n - 1].string_end = lst;
    end
    foreach (unit_bytes[i]) expected_bytes.insert(expected_bytes.size(), unit_bytes[i]);
  endfunction

  task automatic send_unit(input logic [15:0] cu, input logic lst);
    int gap;
    @(negedge clk);
    unit_ch.valid     = 1'b1;
    unit_ch.code_unit = cu;
    unit_ch.unit_last = lst;
    do @(posedge clk); while (!unit_ch.ready);
    encode_unit(cu, lst);
    units_sent++;
    if (lst) strings_sent++;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      unit_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drain();
    @(negedge clk);
    unit_ch.valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_string(output int count);
    logic [15:0] units[$];
    int          len;
    int          sel;
    len = $urandom_range(1, 12);
    while (units.size() < len) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        units.insert(units.size(), 16'($urandom_range(0, 16'h007F)));
      end else if (sel < 30) begin
        units.insert(units.size(), 16'($urandom_range(16'h0080, 16'h07FF)));
      end else if (sel < 40) begin
        units.insert(units.size(), 16'($urandom_range(16'h0800, 16'hD7FF)));
      end else if (sel < 50) begin
        units.insert(units.size(), 16'($urandom_range(16'hE000, 16'hFFFF)));
      end else if (sel < 80) begin
        units.insert(units.size(), 16'($urandom_range(16'hD800, 16'hDBFF)));
        units.insert(units.size(), 16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (sel < 88) begin
        units.insert(units.size(), 16'($urandom_range(16'hD800, 16'hDBFF)));
      end else if (sel < 94) begin
        units.insert(units.size(), 16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else begin
        units.insert(units.size(), 16'($urandom_range(0, 16'hFFFF)));
      end
    end
    foreach (units[i]) send_unit(units[i], i == units.size() - 1);
    count = units.size();
  endtask

  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hD812, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDC01, 1'b0);
    send_unit(16'hD83D, 1'b1);
    send_unit(16'hDB00, 1'b0);
    send_unit(16'hD900, 1'b1);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC37, 1'b1);
    send_unit(16'hDA00, 1'b0);
    send_unit(16'h00E9, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_strings();
    int sent;
    int n;
    sent = 0;
    while (sent < 200) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      send_random_string(n);
      sent += n;
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    int sent;
    int n;
    sent       = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req   = 1'b1;
    while (sent < 30) begin
      send_random_string(n);
      sent += n;
    end
    wait_drain();
  endtask

  task automatic test_steady_stream();
    int sent;
    int n;
    sent       = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (sent < 80) begin
      send_random_string(n);
      sent += n;
    end
    wait_drain();
  endtask

  initial begin
    byte_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        byte_ch.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        byte_ch.ready = 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        byte_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected beat, expected none, actual %h/%b/%b",
                 $time, byte_ch.out_byte, byte_ch.run_last, byte_ch.string_end);
      end else begin
        head_byte = expected_bytes.pop_front();
        if (byte_ch.out_byte !== head_byte.data || byte_ch.run_last !== head_byte.run_last ||
            byte_ch.string_end !== head_byte.string_end) begin
          error_count++;
          $display("%0t: byte/run_last/string_end expected %h/%b/%b, actual %h/%b/%b",
                   $time, head_byte.data, head_byte.run_last, head_byte.string_end,
                   byte_ch.out_byte, byte_ch.run_last, byte_ch.string_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (unit_ch.valid && unit_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d bytes still expected",
                 $time, QUIET_LIMIT, expected_bytes.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst               = 1'b1;
    unit_ch.valid     = 1'b0;
    unit_ch.code_unit = '0;
    unit_ch.unit_last = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_strings();
    test_backpressure();
    test_steady_stream();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
    end
    $display("Run covered %0d code units in %0d strings and %0d UTF-8 byte beats,",
             units_sent, strings_sent, bytes_checked);
    $display("including surrogate pairs, lone surrogates, a long output hold and idle bursts.");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/u2u8_pkg.sv
rtl/u2u8_if.sv
rtl/u2u8_front.sv
rtl/u2u8_queue.sv
rtl/u2u8_back.sv
rtl/utf16_to_utf8_transcoder.sv
tb/tb.sv
